// ===== hdl/generational_handle_allocator_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the generational handle allocator.
// ---------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GHA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/gha_pkg.sv =====
// ---------------------------------------------------------------------------
// gha_pkg
// Types and constants of the generational handle allocator.
// ---------------------------------------------------------------------------
package gha_pkg;

  // Pool capacity and generation width.
  localparam int SLOTS    = 1024;
  localparam int GEN_BITS = 24;

  // Derived widths.
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DESTROY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CHECK   = 2'd2;

  // Response status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

  // One request.
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [IDX_W-1:0]    handle_index;
    logic [GEN_BITS-1:0] handle_generation;
  } req_t;

  // One response.
  typedef struct packed {
    logic [STAT_W-1:0]   status;
    logic [IDX_W-1:0]    slot_index;
    logic [GEN_BITS-1:0] slot_generation;
    logic [CNT_W-1:0]    live_slots;
  } rsp_t;

  // One slot entry in the slot memory. The link is one bit wider than an
  // index so that it can hold SLOTS, the empty-stack marker.
  typedef struct packed {
    logic [CNT_W-1:0]    link;
    logic                busy;
    logic [GEN_BITS-1:0] gen;
  } entry_t;

endpackage

// ===== hdl/gha_ram.sv =====
// ---------------------------------------------------------------------------
// gha_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ---------------------------------------------------------------------------
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port; data holds between reads.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/generational_handle_allocator.sv =====
// ---------------------------------------------------------------------------
// generational_handle_allocator
// Slot allocator that hands out index and generation handles, recycles
// freed slots through a LIFO stack, and validates handles.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  req      in         req_valid/req_stall   kind, handle_index, handle_generation
//  rsp      out        rsp_valid/rsp_stall   status, slot_index, slot_generation,
//                                            live_slots
//
// Each request reads the slot memory in the accept cycle, then compares,
// updates and writes back in S_EXEC, once the response register is free or being read.
// The slot memory has one read and one write port, and the stack top carries
// from one request to the next, so one request is in flight at a time.
// A response waiting on rsp_stall holds the block in S_EXEC only
// when a newer response is ready to replace it.
// Reset is synchronous and clears the control registers; the slot memory is never cleared.
// ---------------------------------------------------------------------------
module generational_handle_allocator
  import gha_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

`include "generational_handle_allocator_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  // Where an allocate takes its slot from.
  localparam logic [1:0] SRC_NONE  = 2'd0;
  localparam logic [1:0] SRC_POP   = 2'd1;
  localparam logic [1:0] SRC_FRESH = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [1:0]          src;
    logic [IDX_W-1:0]    addr;
    logic [GEN_BITS-1:0] gen;
  } op_t;

  state_t state, state_next;
  op_t    op, op_next;

  logic [CNT_W-1:0] free_top, free_top_next;
  logic [CNT_W-1:0] fresh_mark, fresh_mark_next;
  logic [CNT_W-1:0] busy_count, busy_count_next;

  logic       accept, finish;
  logic       wr_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  entry_t     wr_data, rd_data;
  rsp_t       rsp_next;
  logic       handle_valid;
  logic [GEN_BITS-1:0] gen_inc;

  assign req_stall = (state == S_EXEC);
  assign accept    = req_valid && !req_stall;
  assign finish    = (state == S_EXEC) && (!rsp_valid || !rsp_stall);

  // Slot memory: link, busy flag and generation per slot.
  gha_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Pick the slot to read when a request is accepted.
  always_comb begin
    op_next      = op;
    rd_addr      = req.handle_index;
    op_next.kind = req.kind;
    op_next.gen  = req.handle_generation;
    op_next.src  = SRC_NONE;
    if (req.kind == KIND_ALLOC) begin
      if (free_top != CNT_W'(SLOTS)) begin
        op_next.src = SRC_POP;
        rd_addr     = free_top[IDX_W-1:0];
      end else if (fresh_mark < CNT_W'(SLOTS)) begin
        op_next.src = SRC_FRESH;
        rd_addr     = fresh_mark[IDX_W-1:0];
      end
    end
    op_next.addr = rd_addr;
  end

  // Handle check and next generation of the slot read.
  assign handle_valid = ({1'b0, op.addr} < fresh_mark) && (rd_data.gen == op.gen)
                        && rd_data.busy;
  assign gen_inc = (rd_data.gen + GEN_BITS'(1) == '0) ? GEN_BITS'(1)
                                                      : rd_data.gen + GEN_BITS'(1);

  // In S_EXEC, decide, write back and form the response.
  always_comb begin
    wr_en           = 1'b0;
    wr_addr         = op.addr;
    wr_data         = rd_data;
    free_top_next   = free_top;
    fresh_mark_next = fresh_mark;
    busy_count_next = busy_count;
    rsp_next.status          = ST_INVALID;
    rsp_next.slot_index      = '0;
    rsp_next.slot_generation = '0;
    unique case (op.kind)
      KIND_ALLOC: begin
        unique case (op.src)
          SRC_POP: begin
            wr_en           = finish;
            wr_data.busy    = 1'b1;
            free_top_next   = rd_data.link;
            busy_count_next = busy_count + CNT_W'(1);
            rsp_next.status          = ST_OK;
            rsp_next.slot_index      = op.addr;
            rsp_next.slot_generation = rd_data.gen;
          end
          SRC_FRESH: begin
            wr_en           = finish;
            wr_data.link    = '0;
            wr_data.busy    = 1'b1;
            wr_data.gen     = GEN_BITS'(1);
            fresh_mark_next = fresh_mark + CNT_W'(1);
            busy_count_next = busy_count + CNT_W'(1);
            rsp_next.status          = ST_OK;
            rsp_next.slot_index      = op.addr;
            rsp_next.slot_generation = GEN_BITS'(1);
          end
          default: begin
            rsp_next.status = ST_FULL;
          end
        endcase
      end
      KIND_DESTROY: begin
        if (handle_valid) begin
          wr_en           = finish;
          wr_data.link    = free_top;
          wr_data.busy    = 1'b0;
          wr_data.gen     = gen_inc;
          free_top_next   = {1'b0, op.addr};
          busy_count_next = busy_count - CNT_W'(1);
          rsp_next.status = ST_OK;
        end
      end
      KIND_CHECK: begin
        if (handle_valid) begin
          rsp_next.status = ST_OK;
        end
      end
      default: begin
        rsp_next.status = ST_INVALID;
      end
    endcase
    rsp_next.live_slots = busy_count_next;
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_EXEC;
      S_EXEC: if (finish) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_top   <= CNT_W'(SLOTS);
      fresh_mark <= '0;
      busy_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (finish) begin
        free_top   <= free_top_next;
        fresh_mark <= fresh_mark_next;
        busy_count <= busy_count_next;
        rsp_valid  <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid  <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op <= op_next;
    end
    if (finish) begin
      rsp <= rsp_next;
    end
  end

  // Checks on the counters and the response.
  `GHA_ASSERT_NOW(a_count_le_fresh, clk, rst, 1'b1, busy_count <= fresh_mark,
    "busy count above fresh mark")
  `GHA_ASSERT_NOW(a_fresh_range, clk, rst, 1'b1, fresh_mark <= CNT_W'(SLOTS),
    "fresh mark out of range")
  `GHA_ASSERT_NEXT(a_accept_exec, clk, rst, accept, state == S_EXEC,
    "accepted request not executing")
  `GHA_ASSERT_NOW(a_full_count, clk, rst, rsp_valid && (rsp.status == ST_FULL),
    rsp.live_slots == CNT_W'(SLOTS), "full reported with free slots")
  `GHA_ASSERT_NOW(a_alloc_index, clk, rst, rsp_valid && (rsp.slot_generation != '0),
    {1'b0, rsp.slot_index} < fresh_mark, "allocated index never handed out")

endmodule

// ===== bench/generational_handle_allocator_tb.sv =====
// ---------------------------------------------------------------------------
// generational_handle_allocator_tb
// Self-checking bench for the generational handle allocator. A short table
// of directed requests covers reset, handle errors, recycling order and the
// unused kind. Random traffic follows, made mostly of well-formed allocate,
// destroy and check requests on live handles. A final pass fills the pool
// to capacity. Each response is checked against its row's typed-in response
// or, failing that, against an in-bench model of the slot pool.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module generational_handle_allocator_tb;
  import gha_pkg::*;

  // The request kind the block answers as invalid.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  // One row of the directed table: the request, and optionally a typed-in
  // response that replaces the model's prediction.
  typedef struct packed {
    req_t item;
    logic typed;
    rsp_t want;
  } stim_row_t;

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Idle rates in percent for the sender and the receiver.
  int unsigned send_idle_pct = 32;
  int unsigned stall_pct     = 50;
  int unsigned error_count   = 0;

  // Model of the slot pool. A link is wide enough for the empty marker.
  logic [CNT_W-1:0]    link_mem [SLOTS];
  logic [GEN_BITS-1:0] gen_mem  [SLOTS];
  bit                  busy_mem [SLOTS];
  int unsigned         stack_top   = SLOTS;
  int unsigned         fresh_count = 0;
  int unsigned         live_count  = 0;
  int                  live_list[$];

  rsp_t      pending_responses[$];
  rsp_t      want_rsp;
  stim_row_t directed_rows[$];

  generational_handle_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #5_000_000;
    $display("** generational_handle_allocator: FAILED **");
    $finish;
  end

  // A handle is live when its slot was handed out, is in use, and the
  // generation matches.
  function automatic bit handle_is_live(input logic [IDX_W-1:0] idx,
                                        input logic [GEN_BITS-1:0] gen);
    return (idx < fresh_count) && (gen_mem[idx] == gen) && busy_mem[idx];
  endfunction

  // Apply one accepted request to the pool model and return its response.
  function automatic rsp_t predict_response(input req_t item);
    rsp_t                r;
    int unsigned         s;
    logic [GEN_BITS-1:0] next_gen;
    r = '0;
    r.status = ST_INVALID;
    if (item.kind == KIND_ALLOC) begin
      if (stack_top < SLOTS || fresh_count < SLOTS) begin
        if (stack_top < SLOTS) begin
          s = stack_top;
          stack_top = 32'(link_mem[s]);
        end else begin
          s = fresh_count;
          fresh_count++;
          gen_mem[s] = GEN_BITS'(1);
        end
        busy_mem[s] = 1'b1;
        live_count++;
        live_list.insert(live_list.size(), int'(s));
        r.status          = ST_OK;
        r.slot_index      = IDX_W'(s);
        r.slot_generation = gen_mem[s];
      end else begin
        r.status = ST_FULL;
      end
    end else if (item.kind == KIND_DESTROY) begin
      if (handle_is_live(item.handle_index, item.handle_generation)) begin
        // Advance the generation, skipping zero on wrap.
        next_gen = gen_mem[item.handle_index] + 1'b1;
        if (next_gen == '0) next_gen = GEN_BITS'(1);
        gen_mem[item.handle_index]  = next_gen;
        busy_mem[item.handle_index] = 1'b0;
        link_mem[item.handle_index] = CNT_W'(stack_top);
        stack_top = 32'(item.handle_index);
        live_count--;
        for (int k = 0; k < live_list.size(); k++) begin
          if (live_list[k] == item.handle_index) begin
            live_list.delete(k);
            break;
          end
        end
        r.status = ST_OK;
      end
    end else if (item.kind == KIND_CHECK) begin
      if (handle_is_live(item.handle_index, item.handle_generation)) r.status = ST_OK;
    end
    r.live_slots = CNT_W'(live_count);
    return r;
  endfunction

  // Random request, biased toward live handles so that the pool keeps
  // churning, with stale handles, zero generations and noise mixed in.
  function automatic req_t pick_request();
    req_t        r;
    int unsigned roll;
    int unsigned pos;
    r.kind              = KIND_ALLOC;
    r.handle_index      = IDX_W'($urandom);
    r.handle_generation = GEN_BITS'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      r.kind = KIND_ALLOC;
    end else if (roll < 80 && live_list.size() != 0) begin
      pos = $urandom_range(0, live_list.size() - 1);
      r.kind              = (roll < 65) ? KIND_DESTROY : KIND_CHECK;
      r.handle_index      = IDX_W'(live_list[pos]);
      r.handle_generation = gen_mem[live_list[pos]];
    end else if (roll < 87 && fresh_count != 0) begin
      // Stale or wrong generation on a slot that was handed out.
      pos = $urandom_range(0, fresh_count - 1);
      r.kind              = $urandom_range(0, 1) ? KIND_DESTROY : KIND_CHECK;
      r.handle_index      = IDX_W'(pos);
      r.handle_generation = $urandom_range(0, 1) ? gen_mem[pos] - 1'b1 : gen_mem[pos];
    end else if (roll < 93) begin
      r.kind = KIND_W'($urandom_range(0, 3));
    end else if (roll < 97) begin
      r.kind              = $urandom_range(0, 1) ? KIND_DESTROY : KIND_CHECK;
      r.handle_generation = '0;
      if (live_list.size() != 0) begin
        r.handle_index = IDX_W'(live_list[$urandom_range(0, live_list.size() - 1)]);
      end
    end else begin
      r.kind = KIND_UNUSED;
      if (live_list.size() != 0) begin
        pos = live_list[$urandom_range(0, live_list.size() - 1)];
        r.handle_index      = IDX_W'(pos);
        r.handle_generation = gen_mem[pos];
      end
    end
    return r;
  endfunction

  // Append one row to the directed table.
  function automatic void add_row(input logic [KIND_W-1:0] kind,
                                  input logic [IDX_W-1:0] idx,
                                  input logic [GEN_BITS-1:0] gen,
                                  input logic typed,
                                  input logic [STAT_W-1:0] status,
                                  input logic [IDX_W-1:0] slot_idx,
                                  input logic [GEN_BITS-1:0] slot_gen,
                                  input logic [CNT_W-1:0] live);
    stim_row_t row;
    row.item.kind              = kind;
    row.item.handle_index      = idx;
    row.item.handle_generation = gen;
    row.typed                  = typed;
    row.want.status            = status;
    row.want.slot_index        = slot_idx;
    row.want.slot_generation   = slot_gen;
    row.want.live_slots        = live;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Present one request, hold it until accepted, then record its response.
  task automatic issue_request(input req_t item, input logic typed, input rsp_t typed_rsp);
    rsp_t model_rsp;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    model_rsp = predict_response(item);
    pending_responses.insert(pending_responses.size(), typed ? typed_rsp : model_rsp);
  endtask

  // Receiver back-pressure.
  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Compare each accepted response with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_responses.size() == 0) begin
        $error("response with no request outstanding");
        error_count++;
      end else begin
        want_rsp = pending_responses.pop_front();
        if (rsp.status !== want_rsp.status) begin
          $error("status: expected %0d, got %0d", want_rsp.status, rsp.status);
          error_count++;
        end
        if (rsp.slot_index !== want_rsp.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want_rsp.slot_index, rsp.slot_index);
          error_count++;
        end
        if (rsp.slot_generation !== want_rsp.slot_generation) begin
          $error("slot_generation: expected %0d, got %0d",
                 want_rsp.slot_generation, rsp.slot_generation);
          error_count++;
        end
        if (rsp.live_slots !== want_rsp.live_slots) begin
          $error("live_slots: expected %0d, got %0d", want_rsp.live_slots, rsp.live_slots);
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t   row;
    req_t        item;
    int unsigned phase_items [3];
    int unsigned phase_send  [3];
    int unsigned phase_stall [3];
    int unsigned pos;

    // Random traffic stays short, since filling the pool alone takes about
    // a thousand allocates.
    phase_items = '{50, 50, 50};
    phase_send  = '{32, 50, 0};
    phase_stall = '{50, 32, 0};

    // Directed table. Rows marked typed carry their response; the rest
    // are checked against the model.
    add_row(KIND_CHECK,   0, 1, 1, ST_INVALID, 0, 0, 0);
    add_row(KIND_DESTROY, 0, 1, 1, ST_INVALID, 0, 0, 0);
    add_row(KIND_UNUSED, 1023, 24'hFFFFFF, 1, ST_INVALID, 0, 0, 0);
    add_row(KIND_ALLOC,   0, 0, 1, ST_OK, 0, 1, 1);
    add_row(KIND_ALLOC, 1023, 24'hFFFFFF, 1, ST_OK, 1, 1, 2);
    add_row(KIND_CHECK,   0, 1, 1, ST_OK, 0, 0, 2);
    add_row(KIND_CHECK,   0, 0, 1, ST_INVALID, 0, 0, 2);
    add_row(KIND_CHECK, 1023, 24'hFFFFFF, 1, ST_INVALID, 0, 0, 2);
    add_row(KIND_CHECK,   2, 1, 1, ST_INVALID, 0, 0, 2);
    add_row(KIND_DESTROY, 0, 2, 1, ST_INVALID, 0, 0, 2);
    add_row(KIND_DESTROY, 0, 1, 1, ST_OK, 0, 0, 1);
    add_row(KIND_CHECK,   0, 1, 1, ST_INVALID, 0, 0, 1);
    add_row(KIND_DESTROY, 0, 1, 1, ST_INVALID, 0, 0, 1);
    add_row(KIND_ALLOC,   0, 0, 0, ST_OK, 0, 0, 0);
    add_row(KIND_DESTROY, 1, 1, 0, ST_OK, 0, 0, 0);
    add_row(KIND_DESTROY, 0, 2, 0, ST_OK, 0, 0, 0);
    add_row(KIND_ALLOC,   0, 0, 0, ST_OK, 0, 0, 0);
    add_row(KIND_ALLOC,   0, 0, 0, ST_OK, 0, 0, 0);
    add_row(KIND_ALLOC,   0, 0, 0, ST_OK, 0, 0, 0);
    add_row(KIND_CHECK,   1, 2, 0, ST_OK, 0, 0, 0);
    add_row(KIND_UNUSED,  0, 3, 1, ST_INVALID, 0, 0, 3);
    add_row(KIND_DESTROY, 0, 24'hFFFFFF, 1, ST_INVALID, 0, 0, 3);
    add_row(KIND_DESTROY, 2, 0, 1, ST_INVALID, 0, 0, 3);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed requests.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      issue_request(row.item, row.typed, row.want);
    end

    // Random traffic under three idle profiles.
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = phase_send[p];
      stall_pct     = phase_stall[p];
      for (int n = 0; n < phase_items[p]; n++) begin
        issue_request(pick_request(), 1'b0, '0);
      end
    end

    // Fill the pool to capacity, then push past it.
    item = '0;
    item.kind = KIND_ALLOC;
    while (live_count < SLOTS) issue_request(item, 1'b0, '0);
    repeat (3) issue_request(item, 1'b0, '0);

    // With every slot handed out, the top index is in range.
    item.kind              = KIND_CHECK;
    item.handle_index      = IDX_W'(SLOTS - 1);
    item.handle_generation = gen_mem[SLOTS - 1];
    issue_request(item, 1'b0, '0);
    item.handle_generation = 24'hFFFFFF;
    issue_request(item, 1'b0, '0);

    // Release some slots and reuse them, then allocate into a full pool again.
    for (int n = 0; n < 5; n++) begin
      pos = live_list[$urandom_range(0, live_list.size() - 1)];
      item.kind              = KIND_DESTROY;
      item.handle_index      = IDX_W'(pos);
      item.handle_generation = gen_mem[pos];
      issue_request(item, 1'b0, '0);
      item.kind = KIND_CHECK;
      issue_request(item, 1'b0, '0);
    end
    item.kind = KIND_ALLOC;
    repeat (7) issue_request(item, 1'b0, '0);

    // Drain.
    req_valid <= 1'b0;
    stall_pct = 0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (error_count == 0) begin
      $display("** generational_handle_allocator: PASSED **");
    end else begin
      $display("** generational_handle_allocator: FAILED **");
    end
    $finish;
  end

endmodule

// ===== generational_handle_allocator.f =====
+incdir+hdl
hdl/gha_pkg.sv
hdl/gha_ram.sv
hdl/generational_handle_allocator.sv
bench/generational_handle_allocator_tb.sv
